### src/i2cmb_pkg.sv
// shared types and constants for the i2c master bit engine
`timescale 1ns / 1ps

package i2cmb_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned TPU_W       = 10;

  // segment lengths in delay units
  localparam logic [3:0] UNITS_START_HI  = 4'd10;
  localparam logic [3:0] UNITS_START_LO  = 4'd5;
  localparam logic [3:0] UNITS_STOP      = 4'd5;
  localparam logic [3:0] UNITS_WR_LOW    = 4'd2;
  localparam logic [3:0] UNITS_WR_DATA   = 4'd3;
  localparam logic [3:0] UNITS_WR_HIGH   = 4'd5;
  localparam logic [3:0] UNITS_RD_LOW    = 4'd5;
  localparam logic [3:0] UNITS_RD_HIGH   = 4'd2;
  localparam logic [3:0] UNITS_RD_HOLD   = 4'd3;

  localparam logic [1:0] PHASE_0 = 2'd0;
  localparam logic [1:0] PHASE_1 = 2'd1;
  localparam logic [1:0] PHASE_2 = 2'd2;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRB   = 3'd3,
    CMD_RDB   = 3'd4,
    CMD_RACK  = 3'd5,
    CMD_WACK  = 3'd6
  } cmd_t;

  localparam logic [2:0] REQ_TICK = 3'd0;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] byte_out;
    logic       ack_out;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_is_input;
    logic       busy_res;
    logic       done_res;
    logic [7:0] byte_in;
    logic       ack_in;
  } out_item_t;

  typedef struct packed {
    kind_t      kind;
    cmd_t       cmd;
    logic [7:0] byte_out;
    logic       ack_out;
    logic       sda_in;
  } entry_t;

endpackage

### src/i2cmb_front.sv
// front end: input handshake and request classification
`timescale 1ns / 1ps

module i2cmb_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  i2cmb_pkg::in_item_t  in_data,
  input  logic                 q_full,
  output logic                 q_push,
  output i2cmb_pkg::entry_t    q_entry
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_entry.cmd      = i2cmb_pkg::CMD_IDLE;
    q_entry.byte_out = in_data.byte_out;
    q_entry.ack_out  = in_data.ack_out;
    q_entry.sda_in   = in_data.sda_in;
    unique case (in_data.req_type) inside
      i2cmb_pkg::REQ_TICK: begin
        q_entry.kind = i2cmb_pkg::KIND_TICK;
      end
      i2cmb_pkg::CMD_START, i2cmb_pkg::CMD_STOP, i2cmb_pkg::CMD_WRB,
      i2cmb_pkg::CMD_RDB, i2cmb_pkg::CMD_RACK, i2cmb_pkg::CMD_WACK: begin
        q_entry.kind = i2cmb_pkg::KIND_CMD;
        q_entry.cmd  = i2cmb_pkg::cmd_t'(in_data.req_type);
      end
      default: begin
        q_entry.kind = i2cmb_pkg::KIND_NONE;
      end
    endcase
  end

endmodule

### src/i2cmb_queue.sv
// short fifo between the front end and the bit sequencer
`timescale 1ns / 1ps

module i2cmb_queue #(
  parameter int unsigned DEPTH = i2cmb_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  i2cmb_pkg::entry_t  push_entry,
  input  logic               pop,
  output i2cmb_pkg::entry_t  head,
  output logic               full,
  output logic               empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  i2cmb_pkg::entry_t slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### src/i2cmb_back.sv
// back end: bit sequencer, unit timing and result register
`timescale 1ns / 1ps

module i2cmb_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [i2cmb_pkg::TPU_W-1:0]         cfg_wr_data,
  input  logic                                q_empty,
  input  i2cmb_pkg::entry_t                   q_head,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output i2cmb_pkg::out_item_t                out_data
);

  localparam int unsigned TPU_W = i2cmb_pkg::TPU_W;

  logic [TPU_W-1:0]  tpu_r;
  logic [TPU_W-1:0]  tpu_eff;
  i2cmb_pkg::cmd_t   command_r, command_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [3:0]        unit_count_r, unit_count_nxt;
  logic [TPU_W-1:0]  tick_count_r, tick_count_nxt;
  logic [2:0]        bit_index_r, bit_index_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic              sda_dir_in_r, sda_dir_in_nxt;
  logic              ack_r, ack_nxt;
  logic [7:0]        rx_byte_r, rx_byte_nxt;
  logic              done_nxt;
  logic              out_valid_r, out_valid_nxt;
  i2cmb_pkg::out_item_t out_data_r, out_data_nxt;

  logic [TPU_W:0]    tick_inc;
  logic [3:0]        unit_dec;
  logic [2:0]        last_bit;

  assign tpu_eff   = (tpu_r == '0) ? TPU_W'(1) : tpu_r;
  assign q_pop     = !q_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign tick_inc  = {1'b0, tick_count_r} + 1'b1;
  assign unit_dec  = (unit_count_r != 4'd0) ? unit_count_r - 4'd1 : unit_count_r;
  assign last_bit  = (command_r == i2cmb_pkg::CMD_WRB ||
                      command_r == i2cmb_pkg::CMD_RDB) ? 3'd7 : 3'd0;

  // next state
  always_comb begin
    command_nxt    = command_r;
    phase_nxt      = phase_r;
    unit_count_nxt = unit_count_r;
    tick_count_nxt = tick_count_r;
    bit_index_nxt  = bit_index_r;
    shift_nxt      = shift_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    sda_dir_in_nxt = sda_dir_in_r;
    ack_nxt        = ack_r;
    rx_byte_nxt    = rx_byte_r;
    done_nxt       = 1'b0;
    if (q_pop) begin
      if (command_r == i2cmb_pkg::CMD_IDLE) begin
        if (q_head.kind == i2cmb_pkg::KIND_CMD) begin
          command_nxt    = q_head.cmd;
          bit_index_nxt  = 3'd0;
          phase_nxt      = i2cmb_pkg::PHASE_0;
          tick_count_nxt = '0;
          unique case (q_head.cmd)
            i2cmb_pkg::CMD_START: begin
              sda_dir_in_nxt = 1'b0;
              scl_nxt        = 1'b1;
              sda_nxt        = 1'b1;
              unit_count_nxt = i2cmb_pkg::UNITS_START_HI;
            end
            i2cmb_pkg::CMD_STOP: begin
              sda_dir_in_nxt = 1'b0;
              sda_nxt        = 1'b0;
              scl_nxt        = 1'b1;
              unit_count_nxt = i2cmb_pkg::UNITS_STOP;
            end
            i2cmb_pkg::CMD_WRB: begin
              sda_dir_in_nxt = 1'b0;
              shift_nxt      = q_head.byte_out;
              scl_nxt        = 1'b0;
              unit_count_nxt = i2cmb_pkg::UNITS_WR_LOW;
            end
            i2cmb_pkg::CMD_WACK: begin
              sda_dir_in_nxt = 1'b0;
              shift_nxt      = {q_head.ack_out, 7'd0};
              scl_nxt        = 1'b0;
              unit_count_nxt = i2cmb_pkg::UNITS_WR_LOW;
            end
            default: begin
              sda_dir_in_nxt = 1'b1;
              shift_nxt      = 8'd0;
              scl_nxt        = 1'b0;
              unit_count_nxt = i2cmb_pkg::UNITS_RD_LOW;
            end
          endcase
        end
      end else if (q_head.kind == i2cmb_pkg::KIND_TICK) begin
        if (tick_inc >= {1'b0, tpu_eff}) begin
          tick_count_nxt = '0;
          unit_count_nxt = unit_dec;
          if (unit_dec == 4'd0) begin
            done_nxt = 1'b0;
            unique case (command_r)
              i2cmb_pkg::CMD_START: begin
                if (phase_r == i2cmb_pkg::PHASE_0) begin
                  sda_nxt        = 1'b0;
                  phase_nxt      = i2cmb_pkg::PHASE_1;
                  unit_count_nxt = i2cmb_pkg::UNITS_START_LO;
                end else begin
                  scl_nxt  = 1'b0;
                  done_nxt = 1'b1;
                end
              end
              i2cmb_pkg::CMD_STOP: begin
                sda_nxt  = 1'b1;
                done_nxt = 1'b1;
              end
              i2cmb_pkg::CMD_WRB, i2cmb_pkg::CMD_WACK: begin
                if (phase_r == i2cmb_pkg::PHASE_0) begin
                  sda_nxt        = shift_r[7];
                  phase_nxt      = i2cmb_pkg::PHASE_1;
                  unit_count_nxt = i2cmb_pkg::UNITS_WR_DATA;
                end else if (phase_r == i2cmb_pkg::PHASE_1) begin
                  scl_nxt        = 1'b1;
                  phase_nxt      = i2cmb_pkg::PHASE_2;
                  unit_count_nxt = i2cmb_pkg::UNITS_WR_HIGH;
                end else begin
                  shift_nxt = {shift_r[6:0], 1'b0};
                  scl_nxt   = 1'b0;
                  if (bit_index_r < last_bit) begin
                    bit_index_nxt  = bit_index_r + 3'd1;
                    phase_nxt      = i2cmb_pkg::PHASE_0;
                    unit_count_nxt = i2cmb_pkg::UNITS_WR_LOW;
                  end else begin
                    done_nxt = 1'b1;
                  end
                end
              end
              i2cmb_pkg::CMD_RDB, i2cmb_pkg::CMD_RACK: begin
                if (phase_r == i2cmb_pkg::PHASE_0) begin
                  scl_nxt        = 1'b1;
                  phase_nxt      = i2cmb_pkg::PHASE_1;
                  unit_count_nxt = i2cmb_pkg::UNITS_RD_HIGH;
                end else if (phase_r == i2cmb_pkg::PHASE_1) begin
                  shift_nxt      = {shift_r[6:0], q_head.sda_in};
                  phase_nxt      = i2cmb_pkg::PHASE_2;
                  unit_count_nxt = i2cmb_pkg::UNITS_RD_HOLD;
                end else begin
                  scl_nxt = 1'b0;
                  if (bit_index_r < last_bit) begin
                    bit_index_nxt  = bit_index_r + 3'd1;
                    phase_nxt      = i2cmb_pkg::PHASE_0;
                    unit_count_nxt = i2cmb_pkg::UNITS_RD_LOW;
                  end else begin
                    if (command_r == i2cmb_pkg::CMD_RACK) begin
                      ack_nxt = shift_r[0];
                    end else begin
                      rx_byte_nxt = shift_r;
                    end
                    done_nxt = 1'b1;
                  end
                end
              end
              default: begin
                done_nxt = 1'b1;
              end
            endcase
            if (done_nxt) begin
              command_nxt    = i2cmb_pkg::CMD_IDLE;
              phase_nxt      = i2cmb_pkg::PHASE_0;
              unit_count_nxt = 4'd0;
              tick_count_nxt = '0;
              bit_index_nxt  = 3'd0;
            end
          end
        end else begin
          tick_count_nxt = tick_inc[TPU_W-1:0];
        end
      end
    end
  end

  // outputs
  always_comb begin
    out_valid_nxt             = q_pop || (out_valid_r && out_stall);
    out_data_nxt.scl          = scl_nxt;
    out_data_nxt.sda_out      = sda_nxt;
    out_data_nxt.sda_is_input = sda_dir_in_nxt;
    out_data_nxt.busy_res     = (command_nxt != i2cmb_pkg::CMD_IDLE);
    out_data_nxt.done_res     = done_nxt;
    out_data_nxt.byte_in      = rx_byte_nxt;
    out_data_nxt.ack_in       = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r        <= TPU_W'(1);
      command_r    <= i2cmb_pkg::CMD_IDLE;
      phase_r      <= i2cmb_pkg::PHASE_0;
      unit_count_r <= 4'd0;
      tick_count_r <= '0;
      bit_index_r  <= 3'd0;
      shift_r      <= 8'd0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      sda_dir_in_r <= 1'b0;
      ack_r        <= 1'b1;
      rx_byte_r    <= 8'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tpu_r <= cfg_wr_data;
      end
      command_r    <= command_nxt;
      phase_r      <= phase_nxt;
      unit_count_r <= unit_count_nxt;
      tick_count_r <= tick_count_nxt;
      bit_index_r  <= bit_index_nxt;
      shift_r      <= shift_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      sda_dir_in_r <= sda_dir_in_nxt;
      ack_r        <= ack_nxt;
      rx_byte_r    <= rx_byte_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_busy_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.busy_res == (command_r != i2cmb_pkg::CMD_IDLE)))
    else $error("busy flag out of step with sequencer");

  a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (command_r == i2cmb_pkg::CMD_IDLE) |->
      (unit_count_r == 4'd0 && tick_count_r == '0 && phase_r == i2cmb_pkg::PHASE_0))
    else $error("counters left running while idle");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.done_res) |-> !out_data_r.busy_res)
    else $error("done reported while still busy");

  a_drive_for_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (command_r == i2cmb_pkg::CMD_START || command_r == i2cmb_pkg::CMD_STOP ||
     command_r == i2cmb_pkg::CMD_WRB || command_r == i2cmb_pkg::CMD_WACK)
      |-> !sda_dir_in_r)
    else $error("sda released during a driving command");

  a_cmd_ignored_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && command_r != i2cmb_pkg::CMD_IDLE && q_head.kind == i2cmb_pkg::KIND_CMD)
      |=> (command_r == $past(command_r)))
    else $error("command taken while busy");

endmodule

### src/i2c_master_bit_engine_core.sv
// top level of the i2c master bit engine: front end, queue and bit sequencer
// each input transfer is written into the queue, then into the result register as a result
// throughput: one transfer per cycle while the queue is not full and out_stall is low
// the queue decouples the input from the result register so either side may stall alone
// reset (synchronous, rst_n low): lines released, sequencer idle, ticks_per_unit 1, queue empty
`timescale 1ns / 1ps

module i2c_master_bit_engine_core #(
  parameter int unsigned QUEUE_DEPTH = i2cmb_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [i2cmb_pkg::TPU_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  i2cmb_pkg::in_item_t          in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output i2cmb_pkg::out_item_t         out_data
);

  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  i2cmb_pkg::entry_t q_entry;
  i2cmb_pkg::entry_t q_head;

  i2cmb_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  i2cmb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  i2cmb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
